### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define APAS_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define APAS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/apas_pkg.sv
// ----------------------------------------------------------------------------
// apas_pkg
// Types and constants of the audio presence auto switch.
// ----------------------------------------------------------------------------
`default_nettype none

package apas_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int RUN_BITS       = 16;
  localparam int CNT_BITS       = 16;
  localparam int WIN_BITS       = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MODE_BITS      = 2;
  localparam int CMP_BITS       = (RUN_BITS > CNT_BITS) ? RUN_BITS : CNT_BITS;

  // Run counters stop one short of all ones
  localparam logic [RUN_BITS-1:0] RUN_MAX = {{(RUN_BITS-1){1'b1}}, 1'b0};

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(20);
  localparam logic [CNT_BITS-1:0]    ON_WIN_RST    = CNT_BITS'(5);
  localparam logic [CNT_BITS-1:0]    OFF_WIN_RST   = CNT_BITS'(3750);
  localparam logic [WIN_BITS-1:0]    WIN_LEN_RST   = WIN_BITS'(1024);
  localparam logic [SAMPLE_BITS-1:0] ON_LEVEL_RST  = SAMPLE_BITS'(682);
  localparam logic [SAMPLE_BITS-1:0] OFF_LEVEL_RST = SAMPLE_BITS'(341);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_AUTO = 2'd0,
    MODE_ON   = 2'd1,
    MODE_OFF  = 2'd2
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_ON_WIN    = 3'd1,
    CFG_OFF_WIN   = 3'd2,
    CFG_WIN_LEN   = 3'd3,
    CFG_ON_LEVEL  = 3'd4,
    CFG_OFF_LEVEL = 3'd5
  } cfg_idx_t;

  // Per-item control from the top level to the span tracker
  typedef struct packed {
    logic audio;   // an audio sample leaves the input register this cycle
    logic ch;      // its channel
    logic close;   // it closes the window
  } apas_step_t;

endpackage

`default_nettype wire

### rtl/apas_if.sv
// ----------------------------------------------------------------------------
// apas channel interfaces
// Valid/ready channels for converter readings in and switch status out.
// ----------------------------------------------------------------------------
`default_nettype none

interface apas_in_if;
  import apas_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic                   channel;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, kind, channel, sample, input ready);
  modport sink   (input valid, kind, channel, sample, output ready);
endinterface

interface apas_out_if;
  import apas_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 switch_on;
  logic                 signal_seen;
  logic                 window_closed;
  logic [MODE_BITS-1:0] mode_now;

  modport source (output valid, switch_on, signal_seen, window_closed, mode_now,
                  input ready);
  modport sink   (input valid, switch_on, signal_seen, window_closed, mode_now,
                  output ready);
endinterface

`default_nettype wire

### rtl/audio_presence_auto_switch_top.sv
// ----------------------------------------------------------------------------
// audio_presence_auto_switch_top
// Switches an output on audio presence, with forced on and forced off modes.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries converter readings: kind 0 is an audio sample of the
//   given channel, kind 1 a mode selector level. results returns one beat per
//   reading: output state, latest presence decision, window close flag and
//   current mode.
//   A reading is taken into an input register, evaluated in a single pass of
//   compare and saturating count logic, and its result sits in an output
//   register. While the receiver does not stall, a reading can be accepted
//   every cycle, so throughput is 1 beat per cycle. If the receiver stalls,
//   the result holds and one more reading is still taken into the input
//   register before samples.ready drops. Reset (rst, synchronous) empties
//   both registers, restores register defaults, starts a one-sample first
//   window and selects forced on mode with the output on. Registers must be
//   written through cfg_wr_en, cfg_index and cfg_data only while no reading
//   is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_presence_auto_switch_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [apas_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [apas_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  apas_in_if.sink                            samples,
  apas_out_if.source                         results
);
  import apas_pkg::*;

  // Configuration registers
  logic [SAMPLE_BITS-1:0] threshold;
  logic [CNT_BITS-1:0]    on_windows;
  logic [CNT_BITS-1:0]    off_windows;
  logic [WIN_BITS-1:0]    window_length;
  logic [SAMPLE_BITS-1:0] on_level;
  logic [SAMPLE_BITS-1:0] off_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      on_windows    <= ON_WIN_RST;
      off_windows   <= OFF_WIN_RST;
      window_length <= WIN_LEN_RST;
      on_level      <= ON_LEVEL_RST;
      off_level     <= OFF_LEVEL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: threshold     <= cfg_data[SAMPLE_BITS-1:0];
        CFG_ON_WIN:    on_windows    <= cfg_data[CNT_BITS-1:0];
        CFG_OFF_WIN:   off_windows   <= cfg_data[CNT_BITS-1:0];
        CFG_WIN_LEN:   window_length <= cfg_data[WIN_BITS-1:0];
        CFG_ON_LEVEL:  on_level      <= cfg_data[SAMPLE_BITS-1:0];
        CFG_OFF_LEVEL: off_level     <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                   in_valid;
  logic                   in_kind;
  logic                   in_ch;
  logic [SAMPLE_BITS-1:0] in_sample;

  // Output register
  logic                 out_valid;
  logic                 out_switch;
  logic                 out_signal;
  logic                 out_closed;
  logic [MODE_BITS-1:0] out_mode;

  // Block state
  logic [WIN_BITS-1:0] samples_left;
  logic [RUN_BITS-1:0] present_run;
  logic [RUN_BITS-1:0] quiet_run;
  mode_t               mode_reg;
  logic                out_reg;
  logic                signal_reg;

  logic                advance;
  logic                take;
  logic [WIN_BITS-1:0] left_dec;
  logic                close;
  logic                present;
  logic [RUN_BITS-1:0] present_run_next;
  logic [RUN_BITS-1:0] quiet_run_next;
  mode_t               mode_next;
  logic                out_reg_next;
  logic                signal_reg_next;
  apas_step_t          step;

  assign advance       = in_valid && (!out_valid || results.ready);
  assign take          = samples.valid && samples.ready;
  assign samples.ready = !in_valid || advance;

  assign left_dec = samples_left - WIN_BITS'(1);
  assign close    = !in_kind && (left_dec == '0);

  assign step.audio = advance && !in_kind;
  assign step.ch    = in_ch;
  assign step.close = close;

  apas_span_track u_span (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .sample    (in_sample),
    .threshold (threshold),
    .present   (present)
  );

  always_comb begin
    present_run_next = present_run;
    quiet_run_next   = quiet_run;
    signal_reg_next  = signal_reg;
    out_reg_next     = out_reg;
    mode_next        = mode_reg;

    if (in_kind) begin
      if (in_sample > on_level) begin
        mode_next = MODE_ON;
      end else if (in_sample > off_level) begin
        mode_next = MODE_OFF;
      end else begin
        mode_next = MODE_AUTO;
      end
    end else if (close) begin
      if (present) begin
        present_run_next = (present_run < RUN_MAX) ? present_run + RUN_BITS'(1)
                                                   : present_run;
        quiet_run_next   = '0;
      end else begin
        quiet_run_next   = (quiet_run < RUN_MAX) ? quiet_run + RUN_BITS'(1)
                                                 : quiet_run;
        present_run_next = '0;
      end
      signal_reg_next = present;
      case (mode_reg)
        MODE_ON:  out_reg_next = 1'b1;
        MODE_OFF: out_reg_next = 1'b0;
        default: begin
          if (CMP_BITS'(present_run_next) > CMP_BITS'(on_windows)) begin
            out_reg_next = 1'b1;
          end else if (CMP_BITS'(quiet_run_next) > CMP_BITS'(off_windows)) begin
            out_reg_next = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      samples_left <= WIN_BITS'(1);
      present_run  <= '0;
      quiet_run    <= '0;
      mode_reg     <= MODE_ON;
      out_reg      <= 1'b1;
      signal_reg   <= 1'b0;
    end else begin
      if (take) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      if (advance) begin
        if (!in_kind) begin
          // Reload on close; a zero length wraps to a full count
          samples_left <= close ? window_length : left_dec;
        end
        present_run <= present_run_next;
        quiet_run   <= quiet_run_next;
        mode_reg    <= mode_next;
        out_reg     <= out_reg_next;
        signal_reg  <= signal_reg_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      in_kind   <= samples.kind;
      in_ch     <= samples.channel;
      in_sample <= samples.sample;
    end
    if (advance) begin
      out_switch <= out_reg_next;
      out_signal <= signal_reg_next;
      out_closed <= close;
      out_mode   <= mode_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.switch_on     = out_switch;
  assign results.signal_seen   = out_signal;
  assign results.window_closed = out_closed;
  assign results.mode_now      = out_mode;

endmodule

`default_nettype wire

### rtl/apas_span_track.sv
// ----------------------------------------------------------------------------
// apas_span_track
// Running minimum and maximum of both audio channels over the current window,
// and the presence decision for the window that closes with this beat.
// ----------------------------------------------------------------------------
`default_nettype none

module apas_span_track (
  input  logic                            clk,
  input  logic                            rst,
  input  apas_pkg::apas_step_t            step,
  input  logic [apas_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [apas_pkg::SAMPLE_BITS-1:0] threshold,
  output logic                            present
);
  import apas_pkg::*;

  logic [SAMPLE_BITS-1:0] chan_low  [2];
  logic [SAMPLE_BITS-1:0] chan_high [2];
  logic [1:0]             chan_seen;

  logic [SAMPLE_BITS-1:0] low_next  [2];
  logic [SAMPLE_BITS-1:0] high_next [2];
  logic [1:0]             seen_next;
  logic [SAMPLE_BITS-1:0] span      [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      low_next[c]  = chan_low[c];
      high_next[c] = chan_high[c];
      seen_next[c] = chan_seen[c];
      if (step.audio && (step.ch == c[0])) begin
        seen_next[c] = 1'b1;
        if (!chan_seen[c]) begin
          low_next[c]  = sample;
          high_next[c] = sample;
        end else begin
          if (sample < chan_low[c])  low_next[c]  = sample;
          if (sample > chan_high[c]) high_next[c] = sample;
        end
      end
      // An empty channel has no span
      span[c] = seen_next[c] ? (high_next[c] - low_next[c]) : '0;
    end
    present = (span[0] > threshold) || (span[1] > threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_seen <= '0;
    end else if (step.audio) begin
      chan_seen <= step.close ? 2'b00 : seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step.audio) begin
      chan_low[0]  <= low_next[0];
      chan_low[1]  <= low_next[1];
      chan_high[0] <= high_next[0];
      chan_high[1] <= high_next[1];
    end
  end

endmodule

`default_nettype wire

### rtl/apas_checker.sv
// ----------------------------------------------------------------------------
// apas_checker
// Port-level checks on the audio presence auto switch, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module apas_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           switch_on,
  input logic                           signal_seen,
  input logic                           window_closed,
  input logic [apas_pkg::MODE_BITS-1:0] mode_now
);
  import apas_pkg::*;

  // A stalled result holds
  `APAS_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(switch_on) && $stable(signal_seen) && $stable(window_closed) && $stable(mode_now), "result changed while stalled")

  // No result straight out of reset
  `APAS_ASSERT_IMPLY(a_reset_empty, clk, rst, $past(rst), !out_valid, "result valid right after reset")

  // Forced modes decide the output at a window close
  `APAS_ASSERT_IMPLY(a_forced_on, clk, rst, out_valid && window_closed && (mode_now == MODE_ON), switch_on, "forced on close left output off")

  `APAS_ASSERT_IMPLY(a_forced_off, clk, rst, out_valid && window_closed && (mode_now == MODE_OFF), !switch_on, "forced off close left output on")

endmodule

bind audio_presence_auto_switch_top apas_checker u_apas_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .switch_on     (results.switch_on),
  .signal_seen   (results.signal_seen),
  .window_closed (results.window_closed),
  .mode_now      (results.mode_now)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives converter readings through the audio presence auto switch and checks
// every status beat against a cycle-free model of windows, run counters and
// mode selection kept inside the bench. Directed readings cover the mode
// boundaries and window closes in each mode. Random phases follow, each under
// fresh register settings, with idle gaps on both channels. A back-to-back run
// at the end closes a window into a zero window length.
// ----------------------------------------------------------------------------
module tb_top;
  import apas_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned LONG_HOLD   = 400;

  typedef struct packed {
    logic                   kind;
    logic                   channel;
    logic [SAMPLE_BITS-1:0] sample;
  } reading_t;

  typedef struct packed {
    logic                 switch_on;
    logic                 signal_seen;
    logic                 window_closed;
    logic [MODE_BITS-1:0] mode_now;
  } status_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  apas_in_if  in_ch ();
  apas_out_if out_ch ();

  audio_presence_auto_switch_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (in_ch),
    .results  (out_ch)
  );

  always #10 clk = ~clk;

  // Model copy of the registers
  logic [SAMPLE_BITS-1:0] thr_q, on_lvl_q, off_lvl_q;
  logic [CNT_BITS-1:0]    on_win_q, off_win_q;
  logic [WIN_BITS-1:0]    win_len_q;

  // Model copy of the window and switch state
  logic [SAMPLE_BITS-1:0] span_lo [2];
  logic [SAMPLE_BITS-1:0] span_hi [2];
  logic [1:0]             span_live;
  logic [WIN_BITS-1:0]    win_left;
  logic [RUN_BITS-1:0]    loud_run, hush_run;
  mode_t                  mode_q;
  logic                   out_q, sig_q;

  reading_t    readings_pending[$];
  status_t     status_due[$];
  reading_t    next_rd;
  status_t     got_status;
  int unsigned items_queued, items_taken, fail_count, cycles;
  bit          tx_idle_on, rx_idle_on, hold_armed, hold_done, in_took;
  int unsigned tx_gap, rx_stall, rx_hold;

  function automatic int unsigned idle_len(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_edge(int unsigned top, int unsigned usual);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, usual);
    endcase
  endfunction

  // Advance the model by one reading and return the status it yields
  function automatic status_t next_status(reading_t rd);
    status_t                r;
    logic [SAMPLE_BITS-1:0] span0, span1;
    logic                   loud;
    r.window_closed = 1'b0;
    if (rd.kind) begin
      if (rd.sample > on_lvl_q) mode_q = MODE_ON;
      else if (rd.sample > off_lvl_q) mode_q = MODE_OFF;
      else mode_q = MODE_AUTO;
    end else begin
      if (!span_live[rd.channel]) begin
        span_lo[rd.channel]   = rd.sample;
        span_hi[rd.channel]   = rd.sample;
        span_live[rd.channel] = 1'b1;
      end else begin
        if (rd.sample < span_lo[rd.channel]) span_lo[rd.channel] = rd.sample;
        if (rd.sample > span_hi[rd.channel]) span_hi[rd.channel] = rd.sample;
      end
      win_left = win_left - WIN_BITS'(1);
      if (win_left == '0) begin
        // an empty channel has no span
        span0 = span_live[0] ? span_hi[0] - span_lo[0] : '0;
        span1 = span_live[1] ? span_hi[1] - span_lo[1] : '0;
        loud  = (span0 > thr_q) || (span1 > thr_q);
        if (loud) begin
          if (loud_run < RUN_MAX) loud_run = loud_run + RUN_BITS'(1);
          hush_run = '0;
        end else begin
          if (hush_run < RUN_MAX) hush_run = hush_run + RUN_BITS'(1);
          loud_run = '0;
        end
        sig_q = loud;
        case (mode_q)
          MODE_ON:  out_q = 1'b1;
          MODE_OFF: out_q = 1'b0;
          default: begin
            if (loud_run > on_win_q) out_q = 1'b1;
            else if (hush_run > off_win_q) out_q = 1'b0;
          end
        endcase
        win_left        = win_len_q;
        span_live       = '0;
        r.window_closed = 1'b1;
      end
    end
    r.switch_on   = out_q;
    r.signal_seen = sig_q;
    r.mode_now    = mode_q;
    return r;
  endfunction

  task automatic add_reading(int unsigned k, int unsigned c, int unsigned s);
    reading_t rd;
    rd.kind    = k[0];
    rd.channel = c[0];
    rd.sample  = s[SAMPLE_BITS-1:0];
    readings_pending.push_back(rd);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || status_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_THRESHOLD: thr_q     = val[SAMPLE_BITS-1:0];
      CFG_ON_WIN:    on_win_q  = val[CNT_BITS-1:0];
      CFG_OFF_WIN:   off_win_q = val[CNT_BITS-1:0];
      CFG_WIN_LEN:   win_len_q = val[WIN_BITS-1:0];
      CFG_ON_LEVEL:  on_lvl_q  = val[SAMPLE_BITS-1:0];
      default:       off_lvl_q = val[SAMPLE_BITS-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(int unsigned thr, int unsigned on_w, int unsigned off_w,
                            int unsigned len, int unsigned on_l, int unsigned off_l);
    wait_idle();
    write_reg(CFG_THRESHOLD, CFG_DATA_BITS'(thr));
    write_reg(CFG_ON_WIN, CFG_DATA_BITS'(on_w));
    write_reg(CFG_OFF_WIN, CFG_DATA_BITS'(off_w));
    write_reg(CFG_WIN_LEN, CFG_DATA_BITS'(len));
    write_reg(CFG_ON_LEVEL, CFG_DATA_BITS'(on_l));
    write_reg(CFG_OFF_LEVEL, CFG_DATA_BITS'(off_l));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Take input beats and predict their status
  always @(posedge clk) begin
    in_took <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      status_due.push_back(next_status('{in_ch.kind, in_ch.channel, in_ch.sample}));
      items_taken++;
    end
  end

  // Offer readings, with a random gap after each beat
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (tx_gap != 0) begin
        tx_gap      <= tx_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (readings_pending.size() != 0) begin
        next_rd        = readings_pending.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= next_rd.kind;
        in_ch.channel <= next_rd.channel;
        in_ch.sample  <= next_rd.sample;
        tx_gap        <= idle_len(tx_idle_on);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure; one long hold-off lets the block fill up
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold      <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done    <= 1'b1;
      rx_hold      <= LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall     <= rx_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 4) == 0) rx_stall <= idle_len(rx_idle_on);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (status_due.size() == 0) begin
        $error("status beat with nothing pending");
        fail_count++;
      end else begin
        got_status = status_due.pop_front();
        check_field("switch_on", {1'b0, got_status.switch_on}, {1'b0, out_ch.switch_on});
        check_field("signal_seen", {1'b0, got_status.signal_seen},
                    {1'b0, out_ch.signal_seen});
        check_field("window_closed", {1'b0, got_status.window_closed},
                    {1'b0, out_ch.window_closed});
        check_field("mode_now", got_status.mode_now, out_ch.mode_now);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int unsigned i, p, n, s;
    bit          loud;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_THRESHOLD;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = 1'b0;
    in_ch.channel = 1'b0;
    in_ch.sample  = '0;
    out_ch.ready  = 1'b0;

    thr_q      = THRESHOLD_RST;
    on_win_q   = ON_WIN_RST;
    off_win_q  = OFF_WIN_RST;
    win_len_q  = WIN_LEN_RST;
    on_lvl_q   = ON_LEVEL_RST;
    off_lvl_q  = OFF_LEVEL_RST;
    span_lo    = '{'0, '0};
    span_hi    = '{'0, '0};
    span_live  = '0;
    win_left   = WIN_BITS'(1);
    loud_run   = '0;
    hush_run   = '0;
    mode_q     = MODE_ON;
    out_q      = 1'b1;
    sig_q      = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Mode boundaries at reset levels
    add_reading(1, 0, 683);
    add_reading(1, 1, 682);
    add_reading(1, 0, 342);
    add_reading(1, 1, 341);
    add_reading(1, 0, 0);
    add_reading(1, 0, 1023);

    // Short windows, zero threshold and zero run limits, written before the
    // one-sample first window closes so that its reload takes the new length
    set_config(0, 0, 0, 2, 1023, 0);
    add_reading(0, 0, 1023);
    add_reading(1, 1, 0);
    add_reading(0, 0, 0);
    add_reading(0, 0, 1023);
    add_reading(0, 1, 5);
    add_reading(0, 1, 5);
    add_reading(0, 0, 9);
    add_reading(0, 1, 200);
    add_reading(0, 0, 3);
    add_reading(0, 0, 4);
    add_reading(1, 0, 1023);
    add_reading(0, 0, 0);
    add_reading(0, 1, 1023);
    add_reading(1, 1, 1);
    add_reading(1, 0, 0);

    loud = 1'b0;
    for (p = 0; p < 8; p++) begin
      set_config(pick_edge(1023, 80), pick_edge(65534, 6), pick_edge(65534, 6),
                 $urandom_range(1, 8), pick_edge(1023, 1023), pick_edge(1023, 1023));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (p == 0) hold_armed = 1'b1;
      for (i = 0; i < 200; i++) begin
        if ($urandom_range(0, 7) == 0) loud = ($urandom_range(0, 1) != 0);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 5))
            0:       s = 0;
            1:       s = int'(off_lvl_q);
            2:       s = int'(off_lvl_q) + 1;
            3:       s = int'(on_lvl_q);
            4:       s = int'(on_lvl_q) + 1;
            default: s = $urandom_range(0, 1023);
          endcase
          add_reading(1, $urandom_range(0, 1), s);
        end else begin
          s = loud ? $urandom_range(0, 1023) : 500 + $urandom_range(0, 16);
          add_reading(0, $urandom_range(0, 1), s);
        end
      end
    end

    // Back-to-back: close the current window into a zero length, which wraps
    // the window counter to a full count, so no further window closes here
    set_config(20, 5, 3750, 0, 682, 341);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    n = int'(win_left) + 48;
    for (i = 0; i < n; i++) add_reading(0, $urandom_range(0, 1), $urandom_range(0, 1023));

    wait_idle();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### audio_presence_auto_switch_top.f
+incdir+rtl
rtl/apas_pkg.sv
rtl/apas_if.sv
rtl/apas_span_track.sv
rtl/audio_presence_auto_switch_top.sv
rtl/apas_checker.sv
bench/tb_top.sv
